@@ sv/hssc_pkg.sv @@
// Shared operation and status codes, commutation tables and types for the Hall commutator.
package hssc_pkg;

  localparam logic [2:0] OP_HALL_EDGE  = 3'd0;
  localparam logic [2:0] OP_SET_DRIVE  = 3'd1;
  localparam logic [2:0] OP_CURRENT    = 3'd2;
  localparam logic [2:0] OP_FAULT      = 3'd3;
  localparam logic [2:0] OP_LOAD_COUNT = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_REJECTED  = 2'd1;
  localparam logic [1:0] ST_FORBIDDEN = 2'd2;

  localparam logic [1:0] PHASE_ONE   = 2'd0;
  localparam logic [1:0] PHASE_TWO   = 2'd1;
  localparam logic [1:0] PHASE_THREE = 2'd2;

  localparam logic [14:0] DUTY_LIMIT_RESET = 15'h7FFF;

  typedef struct packed {
    logic        [2:0]  enable;
    logic        [14:0] duty_one;
    logic        [14:0] duty_two;
    logic        [14:0] duty_three;
    logic        [1:0]  phase;
    logic        [15:0] angle;
    logic signed [15:0] drive;
    logic               count_up;
    logic               count_down;
    logic               forbidden;
  } comm_t;

  function automatic logic [15:0] angle_of(input logic [2:0] hall);
    case (hall)
      3'd1:    angle_of = 16'd54613;
      3'd2:    angle_of = 16'd32768;
      3'd3:    angle_of = 16'd43690;
      3'd4:    angle_of = 16'd10923;
      3'd6:    angle_of = 16'd21845;
      default: angle_of = 16'd0;
    endcase
  endfunction

  function automatic logic [2:0] enable_of(input logic [2:0] hall);
    case (hall)
      3'd1, 3'd6: enable_of = 3'h6;
      3'd2, 3'd5: enable_of = 3'h3;
      3'd3, 3'd4: enable_of = 3'h5;
      default:    enable_of = 3'h0;
    endcase
  endfunction

  function automatic logic [1:0] cw_phase(input logic [2:0] hall);
    case (hall)
      3'd1, 3'd3: cw_phase = PHASE_THREE;
      3'd2, 3'd6: cw_phase = PHASE_TWO;
      default:    cw_phase = PHASE_ONE;
    endcase
  endfunction

  function automatic logic [1:0] ccw_phase(input logic [2:0] hall);
    case (hall)
      3'd1, 3'd5: ccw_phase = PHASE_TWO;
      3'd4, 3'd6: ccw_phase = PHASE_THREE;
      default:    ccw_phase = PHASE_ONE;
    endcase
  endfunction

  // Predecessor of each Hall code in forward and reverse rotation
  function automatic logic [2:0] up_from(input logic [2:0] hall);
    case (hall)
      3'd1:    up_from = 3'd3;
      3'd2:    up_from = 3'd6;
      3'd3:    up_from = 3'd2;
      3'd4:    up_from = 3'd5;
      3'd5:    up_from = 3'd1;
      3'd6:    up_from = 3'd4;
      default: up_from = 3'd0;
    endcase
  endfunction

  function automatic logic [2:0] down_from(input logic [2:0] hall);
    case (hall)
      3'd1:    down_from = 3'd5;
      3'd2:    down_from = 3'd3;
      3'd3:    down_from = 3'd1;
      3'd4:    down_from = 3'd6;
      3'd5:    down_from = 3'd4;
      3'd6:    down_from = 3'd2;
      default: down_from = 3'd0;
    endcase
  endfunction

endpackage

@@ sv/hssc_commutate.sv @@
// Six-step commutation decode: enables, compare values, angle and counting direction.
module hssc_commutate (
  input  logic        [2:0]  hall,
  input  logic        [2:0]  prev_hall,
  input  logic signed [15:0] drive,
  output hssc_pkg::comm_t    comm
);
  import hssc_pkg::*;

  logic [14:0] magnitude;
  logic [15:0] negated;
  logic [1:0]  phase;

  assign negated   = 16'd0 - drive;
  assign magnitude = drive[15] ? negated[14:0] : drive[14:0];
  assign phase     = drive[15] ? ccw_phase(hall) : cw_phase(hall);

  always_comb begin
    comm            = '0;
    comm.angle      = angle_of(hall);
    comm.forbidden  = hall inside {3'd0, 3'd7};
    comm.phase      = phase;
    if (!comm.forbidden) begin
      comm.enable     = enable_of(hall);
      comm.drive      = drive;
      comm.duty_one   = (phase == PHASE_ONE)   ? magnitude : 15'd0;
      comm.duty_two   = (phase == PHASE_TWO)   ? magnitude : 15'd0;
      comm.duty_three = (phase == PHASE_THREE) ? magnitude : 15'd0;
      comm.count_up   = (prev_hall == up_from(hall));
      comm.count_down = (prev_hall != up_from(hall)) && (prev_hall == down_from(hall));
    end
  end

endmodule

@@ sv/hall_six_step_commutator.sv @@
// Top level of the BLDC six-step Hall commutator.
//
// Requests come in on the in_valid/in_ready channel: operation, Hall bits, a
// signed drive request, three phase currents and a counter load value.
// Every request gives exactly one result on out_valid/out_ready, showing the
// commutator state after that request plus a status code.
// An accepted request is held in an input register; its result is registered
// into the state/result registers once the output can advance. Throughput is
// one request per cycle while out_ready stays high; all decode is a single
// shallow pass of table lookups, one 17-bit compare and a 32-bit up/down
// count between the input and state/result registers. When the receiver
// stalls, the result holds and one further request is still taken into the
// input register; in_ready then drops until the result is taken. The user
// must see that duty_limit is written through cfg_we/cfg_wdata only while
// the block is idle; the block itself does not enforce this. Synchronous
// reset clears all state: outputs off, drive and position zero, duty_limit
// back to its maximum, and both channels empty.
module hall_six_step_commutator (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic        [14:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [2:0]  operation,
  input  logic        [2:0]  hall_bits,
  input  logic signed [16:0] drive_request,
  input  logic signed [15:0] current_a,
  input  logic signed [15:0] current_b,
  input  logic signed [15:0] current_c,
  input  logic signed [31:0] count_load,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [2:0]  phase_enable,
  output logic        [14:0] duty_one,
  output logic        [14:0] duty_two,
  output logic        [14:0] duty_three,
  output logic signed [31:0] position,
  output logic        [15:0] electrical_angle,
  output logic        [2:0]  hall_now,
  output logic signed [15:0] drive_now,
  output logic signed [15:0] conducting_current,
  output logic        [1:0]  status
);
  import hssc_pkg::*;

  logic [14:0] duty_limit;

  // input register
  logic               req_valid;
  logic [2:0]         req_op;
  logic [2:0]         req_hall;
  logic signed [16:0] req_drive;
  logic signed [15:0] req_ia;
  logic signed [15:0] req_ib;
  logic signed [15:0] req_ic;
  logic signed [31:0] req_load;

  // commutator state, driven straight to the result ports
  logic [2:0]         hall_state;
  logic signed [15:0] drive_value;
  logic [31:0]        position_count;
  logic [15:0]        angle_reg;
  logic [1:0]         driven_phase;
  logic [15:0]        phase_current;
  logic [14:0]        duty_a;
  logic [14:0]        duty_b;
  logic [14:0]        duty_c;
  logic [2:0]         enable_reg;
  logic [1:0]         status_reg;
  logic               result_valid;

  logic               advance;
  logic               step;
  logic [16:0]        req_negated;
  logic [16:0]        req_magnitude;
  logic               in_range;
  logic signed [15:0] apply_drive;
  logic               do_apply;
  comm_t              comm;

  assign advance  = !result_valid || out_ready;
  assign in_ready = !req_valid || advance;
  assign step     = req_valid && advance;

  assign req_negated   = 17'd0 - req_drive;
  assign req_magnitude = req_drive[16] ? req_negated : req_drive;
  assign in_range      = req_magnitude <= {2'b00, duty_limit};
  assign apply_drive   = (req_op == OP_SET_DRIVE) ? req_drive[15:0] : drive_value;
  assign do_apply      = (req_op == OP_HALL_EDGE) || ((req_op == OP_SET_DRIVE) && in_range);

  hssc_commutate u_commutate (
    .hall      (req_hall),
    .prev_hall (hall_state),
    .drive     (apply_drive),
    .comm      (comm)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_limit <= DUTY_LIMIT_RESET;
    end else if (cfg_we) begin
      duty_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op    <= operation;
      req_hall  <= hall_bits;
      req_drive <= drive_request;
      req_ia    <= current_a;
      req_ib    <= current_b;
      req_ic    <= current_c;
      req_load  <= count_load;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hall_state     <= 3'd0;
      drive_value    <= '0;
      position_count <= 32'd0;
      angle_reg      <= 16'd0;
      driven_phase   <= PHASE_ONE;
      phase_current  <= 16'd0;
      duty_a         <= 15'd0;
      duty_b         <= 15'd0;
      duty_c         <= 15'd0;
      enable_reg     <= 3'd0;
      status_reg     <= ST_OK;
    end else if (step) begin
      status_reg <= ST_OK;
      if (do_apply) begin
        hall_state  <= req_hall;
        angle_reg   <= comm.angle;
        enable_reg  <= comm.enable;
        duty_a      <= comm.duty_one;
        duty_b      <= comm.duty_two;
        duty_c      <= comm.duty_three;
        drive_value <= comm.drive;
        if (comm.forbidden) begin
          status_reg <= ST_FORBIDDEN;
        end else begin
          driven_phase <= comm.phase;
          if (comm.count_up) begin
            position_count <= position_count + 32'd1;
          end else if (comm.count_down) begin
            position_count <= position_count - 32'd1;
          end
        end
      end else begin
        case (req_op)
          OP_SET_DRIVE: begin
            status_reg <= ST_REJECTED;
          end
          OP_CURRENT: begin
            case (driven_phase)
              PHASE_ONE:   phase_current <= req_ia;
              PHASE_TWO:   phase_current <= req_ib;
              PHASE_THREE: phase_current <= req_ic;
              default:     phase_current <= phase_current;
            endcase
          end
          OP_FAULT: begin
            enable_reg  <= 3'd0;
            duty_a      <= 15'd0;
            duty_b      <= 15'd0;
            duty_c      <= 15'd0;
            drive_value <= '0;
          end
          OP_LOAD_COUNT: begin
            position_count <= req_load;
          end
          default: begin
            status_reg <= ST_OK;
          end
        endcase
      end
    end
  end

  assign out_valid          = result_valid;
  assign phase_enable       = enable_reg;
  assign duty_one           = duty_a;
  assign duty_two           = duty_b;
  assign duty_three         = duty_c;
  assign position           = position_count;
  assign electrical_angle   = angle_reg;
  assign hall_now           = hall_state;
  assign drive_now          = drive_value;
  assign conducting_current = phase_current;
  assign status             = status_reg;

endmodule

@@ tb/hall_six_step_commutator_tb.sv @@
// Self-checking testbench for the Hall six-step commutator: random and directed requests.
`timescale 1ns / 1ps

module hall_six_step_commutator_tb;
  import hssc_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int LONG_HOLD      = 60;

  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  // Hall codes in forward rotation order
  localparam logic [5:0][2:0] FWD_RING = {3'd3, 3'd2, 3'd6, 3'd4, 3'd5, 3'd1};

  // Lookups indexed by Hall code, code 7 first
  localparam logic [7:0][15:0] ANGLE_LUT = {16'd0, 16'd21845, 16'd0, 16'd10923,
                                            16'd43690, 16'd32768, 16'd54613, 16'd0};
  localparam logic [7:0][2:0] ENABLE_LUT = {3'd0, 3'd6, 3'd3, 3'd5, 3'd5, 3'd3, 3'd6, 3'd0};
  localparam logic [7:0][1:0] CW_LUT = {PHASE_ONE, PHASE_TWO, PHASE_ONE, PHASE_ONE,
                                        PHASE_THREE, PHASE_TWO, PHASE_THREE, PHASE_ONE};
  localparam logic [7:0][1:0] CCW_LUT = {PHASE_ONE, PHASE_THREE, PHASE_TWO, PHASE_THREE,
                                         PHASE_ONE, PHASE_ONE, PHASE_TWO, PHASE_ONE};

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  hall;
    logic [16:0] drive;
    logic [15:0] cur_a;
    logic [15:0] cur_b;
    logic [15:0] cur_c;
    logic [31:0] load;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  enable;
    logic [14:0] duty_one;
    logic [14:0] duty_two;
    logic [14:0] duty_three;
    logic [31:0] pos;
    logic [15:0] angle;
    logic [2:0]  hall;
    logic [15:0] drive;
    logic [15:0] current;
    logic [1:0]  status;
  } res_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic        [14:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic        [2:0]  operation = '0;
  logic        [2:0]  hall_bits = '0;
  logic signed [16:0] drive_request = '0;
  logic signed [15:0] current_a = '0;
  logic signed [15:0] current_b = '0;
  logic signed [15:0] current_c = '0;
  logic signed [31:0] count_load = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic        [2:0]  phase_enable;
  logic        [14:0] duty_one;
  logic        [14:0] duty_two;
  logic        [14:0] duty_three;
  logic signed [31:0] position;
  logic        [15:0] electrical_angle;
  logic        [2:0]  hall_now;
  logic signed [15:0] drive_now;
  logic signed [15:0] conducting_current;
  logic        [1:0]  status;

  hall_six_step_commutator u_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .operation          (operation),
    .hall_bits          (hall_bits),
    .drive_request      (drive_request),
    .current_a          (current_a),
    .current_b          (current_b),
    .current_c          (current_c),
    .count_load         (count_load),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .phase_enable       (phase_enable),
    .duty_one           (duty_one),
    .duty_two           (duty_two),
    .duty_three         (duty_three),
    .position           (position),
    .electrical_angle   (electrical_angle),
    .hall_now           (hall_now),
    .drive_now          (drive_now),
    .conducting_current (conducting_current),
    .status             (status)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Commutator state as the testbench sees it
  logic        [14:0]      lim_m = DUTY_LIMIT_RESET;
  logic        [2:0]       hall_m = '0;
  logic signed [15:0]      drive_m = '0;
  logic        [31:0]      pos_m = '0;
  logic        [15:0]      angle_m = '0;
  logic        [1:0]       phase_m = PHASE_ONE;
  logic        [15:0]      cur_m = '0;
  logic        [2:0][14:0] duty_m = '0;
  logic        [2:0]       en_m = '0;

  cmd_t request_queue[$];
  res_t awaited_outputs[$];

  int  fail_count  = 0;
  bit  req_taken   = 1'b0;
  bit  idle_on     = 1'b1;
  int  send_gap    = 0;
  int  stall_left  = 0;
  int  hold_left   = 0;
  int  hold_asks   = 0;
  int  hold_served = 0;
  int  gen_limit   = DUTY_LIMIT_RESET;
  int  gen_idx     = 0;
  int  gen_dir     = 1;

  function automatic int ring_pos(input logic [2:0] h);
    for (int i = 0; i < 6; i++)
      if (FWD_RING[i] == h) return i;
    return -1;
  endfunction

  function automatic logic [1:0] apply_drive(input logic [2:0] h,
                                             input logic signed [15:0] drv);
    logic [2:0]         prev;
    logic signed [15:0] mag;
    int                 idx;
    prev = hall_m;
    hall_m = h;
    angle_m = ANGLE_LUT[h];
    duty_m = '0;
    idx = ring_pos(h);
    if (idx < 0) begin
      en_m = '0;
      drive_m = '0;
      return ST_FORBIDDEN;
    end
    en_m = ENABLE_LUT[h];
    if (drv >= 0) begin
      phase_m = CW_LUT[h];
      mag = drv;
    end else begin
      phase_m = CCW_LUT[h];
      mag = -drv;
    end
    duty_m[phase_m] = mag[14:0];
    // only a step to a ring neighbour moves the count
    if (prev == FWD_RING[(idx + 5) % 6])
      pos_m = pos_m + 32'd1;
    else if (prev == FWD_RING[(idx + 1) % 6])
      pos_m = pos_m - 32'd1;
    drive_m = drv;
    return ST_OK;
  endfunction

  function automatic res_t commutate(input cmd_t c);
    res_t       r;
    int         rq;
    int         lm;
    logic [1:0] st;
    st = ST_OK;
    rq = $signed(c.drive);
    lm = lim_m;
    case (c.op)
      OP_HALL_EDGE: st = apply_drive(c.hall, drive_m);
      OP_SET_DRIVE: begin
        if (rq >= -lm && rq <= lm) st = apply_drive(c.hall, 16'(rq));
        else st = ST_REJECTED;
      end
      OP_CURRENT: begin
        case (phase_m)
          PHASE_ONE:   cur_m = c.cur_a;
          PHASE_TWO:   cur_m = c.cur_b;
          PHASE_THREE: cur_m = c.cur_c;
          default:     ;
        endcase
      end
      OP_FAULT: begin
        en_m = '0;
        duty_m = '0;
        drive_m = '0;
      end
      OP_LOAD_COUNT: pos_m = c.load;
      default: ;
    endcase
    r.enable = en_m;
    r.duty_one = duty_m[PHASE_ONE];
    r.duty_two = duty_m[PHASE_TWO];
    r.duty_three = duty_m[PHASE_THREE];
    r.pos = pos_m;
    r.angle = angle_m;
    r.hall = hall_m;
    r.drive = drive_m;
    r.current = cur_m;
    r.status = st;
    return r;
  endfunction

  function automatic string res_str(input res_t r);
    return $sformatf("en=%h duty=%h/%h/%h pos=%h ang=%h hall=%h drv=%h cur=%h st=%h",
                     r.enable, r.duty_one, r.duty_two, r.duty_three, r.pos, r.angle,
                     r.hall, r.drive, r.current, r.status);
  endfunction

  function automatic cmd_t mk_req(input logic [2:0] op, input logic [2:0] hall,
                                  input logic [16:0] drive, input logic [31:0] load);
    cmd_t c;
    c.op = op;
    c.hall = hall;
    c.drive = drive;
    c.cur_a = 16'($urandom);
    c.cur_b = 16'($urandom);
    c.cur_c = 16'($urandom);
    c.load = load;
    return c;
  endfunction

  function automatic void push_req(input logic [2:0] op, input logic [2:0] hall,
                                   input logic [16:0] drive, input logic [31:0] load);
    request_queue.push_back(mk_req(op, hall, drive, load));
  endfunction

  // Mostly legal rotation with in-range drives; the rest is noise
  function automatic cmd_t next_req();
    cmd_t c;
    int   pick;
    int   mag;
    c = mk_req(OP_HALL_EDGE, 3'($urandom), 17'($urandom), $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      if ($urandom_range(0, 9) == 0) gen_dir = -gen_dir;
      if ($urandom_range(0, 5) != 0) gen_idx = (gen_idx + gen_dir + 6) % 6;
      c.hall = FWD_RING[gen_idx];
      if (pick >= 38) begin
        c.op = OP_SET_DRIVE;
        mag = ($urandom_range(0, 3) == 0) ? gen_limit : $urandom_range(0, gen_limit);
        c.drive = 17'($urandom_range(0, 1) ? -mag : mag);
      end
    end else if (pick < 68) begin
      c.op = OP_CURRENT;
    end else if (pick < 73) begin
      c.op = OP_FAULT;
    end else if (pick < 79) begin
      c.op = OP_LOAD_COUNT;
      case ($urandom_range(0, 3))
        0:       c.load = 32'h7FFF_FFFF;
        1:       c.load = 32'h8000_0000;
        2:       c.load = 32'hFFFF_FFFF;
        default: ;
      endcase
    end else if (pick < 87) begin
      c.op = OP_SET_DRIVE;
      if ($urandom_range(0, 1) != 0) begin
        mag = $urandom_range(gen_limit + 1, 65535);
        c.drive = 17'($urandom_range(0, 1) ? -mag : mag);
      end
    end else if (pick < 94) begin
      // any Hall code, forbidden ones included
      if (ring_pos(c.hall) >= 0) gen_idx = ring_pos(c.hall);
    end else begin
      c.op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    end
    return c;
  endfunction

  // Request driver
  always @(negedge clk) begin
    cmd_t c;
    if (!rst && (!in_valid || req_taken)) begin
      if (send_gap == 0 && idle_on && $urandom_range(0, 7) == 0)
        send_gap = $urandom_range(1, 10);
      if (send_gap > 0 || request_queue.size() == 0) begin
        if (send_gap > 0) send_gap--;
        in_valid <= 1'b0;
      end else begin
        c = request_queue.pop_front();
        operation <= c.op;
        hall_bits <= c.hall;
        drive_request <= c.drive;
        current_a <= c.cur_a;
        current_b <= c.cur_b;
        current_c <= c.cur_c;
        count_load <= c.load;
        in_valid <= 1'b1;
      end
    end
  end

  // Result receiver: random stalls plus the occasional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_asks != hold_served) begin
      hold_served++;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor and predictor
  always @(posedge clk) begin
    res_t got;
    res_t want;
    cmd_t seen;
    if (rst) begin
      req_taken = 1'b0;
    end else begin
      if (cfg_we) lim_m = cfg_wdata;
      if (out_valid && out_ready) begin
        got = {phase_enable, duty_one, duty_two, duty_three, position, electrical_angle,
               hall_now, drive_now, conducting_current, status};
        if (awaited_outputs.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("%0t: result with none pending: %s", $realtime,
                                         res_str(got));
        end else begin
          want = awaited_outputs.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch", $realtime);
              $display("  expected %s", res_str(want));
              $display("  actual   %s", res_str(got));
            end
          end
        end
      end
      req_taken = in_valid && in_ready;
      if (req_taken) begin
        seen = {operation, hall_bits, drive_request, current_a, current_b, current_c,
                count_load};
        awaited_outputs.push_back(commutate(seen));
      end
    end
  end

  task automatic drain();
    while (request_queue.size() != 0 || in_valid || awaited_outputs.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_limit(input logic [14:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    gen_limit = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int n);
    for (int k = 0; k < n; k++) request_queue.push_back(next_req());
    drain();
  endtask

  initial begin
    cmd_t c;
    int   k;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // forbidden codes straight out of reset
    push_req(OP_HALL_EDGE, 3'd0, 17'd0, 32'd0);
    push_req(OP_HALL_EDGE, 3'd7, 17'd0, 32'd0);
    push_req(OP_SET_DRIVE, 3'd1, 17'd32767, 32'd0);
    push_req(OP_HALL_EDGE, 3'd5, 17'd0, 32'd0);
    c = mk_req(OP_CURRENT, 3'd0, 17'd0, 32'd0);
    c.cur_a = 16'h7FFF;
    c.cur_b = 16'h8000;
    c.cur_c = 16'h8000;
    request_queue.push_back(c);
    push_req(OP_SET_DRIVE, 3'd4, 17'h1_8001, 32'd0);
    c = mk_req(OP_CURRENT, 3'd0, 17'd0, 32'd0);
    c.cur_a = 16'h8000;
    c.cur_b = 16'h7FFF;
    c.cur_c = 16'h7FFF;
    request_queue.push_back(c);
    // just beyond the limit and the field extremes, all rejected
    push_req(OP_SET_DRIVE, 3'd6, 17'h0_8000, 32'd0);
    push_req(OP_SET_DRIVE, 3'd6, 17'h1_8000, 32'd0);
    push_req(OP_SET_DRIVE, 3'd6, 17'h1_0000, 32'd0);
    push_req(OP_SET_DRIVE, 3'd6, 17'h0_FFFF, 32'd0);
    push_req(OP_HALL_EDGE, 3'd5, 17'd0, 32'd0);
    push_req(OP_HALL_EDGE, 3'd2, 17'd0, 32'd0);
    // count wraps both ways
    push_req(OP_LOAD_COUNT, 3'd0, 17'd0, 32'h7FFF_FFFF);
    push_req(OP_HALL_EDGE, 3'd3, 17'd0, 32'd0);
    push_req(OP_HALL_EDGE, 3'd2, 17'd0, 32'd0);
    push_req(OP_LOAD_COUNT, 3'd0, 17'd0, 32'h8000_0000);
    push_req(OP_HALL_EDGE, 3'd6, 17'd0, 32'd0);
    push_req(OP_SET_DRIVE, 3'd4, 17'd0, 32'd0);
    push_req(OP_FAULT, 3'd0, 17'd0, 32'd0);
    push_req(OP_CURRENT, 3'd0, 17'd0, 32'd0);
    push_req(OP_SPARE_FIRST, 3'd7, 17'h1_FFFF, 32'hFFFF_FFFF);
    push_req(3'(OP_SPARE_FIRST + 1), 3'd3, 17'd5, 32'd0);
    push_req(OP_SPARE_LAST, 3'd1, 17'd0, 32'd1);
    push_req(OP_SET_DRIVE, 3'd0, 17'd100, 32'd0);
    push_req(OP_SET_DRIVE, 3'd7, 17'h1_FF9C, 32'd0);
    push_req(OP_LOAD_COUNT, 3'd0, 17'd0, 32'hFFFF_FFFF);
    push_req(OP_HALL_EDGE, 3'd1, 17'd0, 32'd0);
    drain();

    write_limit(15'd0);
    run_random(100);
    write_limit(15'h7FFF);
    hold_asks++;
    run_random(200);
    write_limit(15'd1000);
    run_random(200);
    write_limit(15'($urandom_range(2, 32766)));
    run_random(200);
    write_limit(15'd1);
    idle_on = 1'b0;
    run_random(250);

    for (k = 0; k < 2000 && awaited_outputs.size() != 0; k++) @(negedge clk);
    repeat (5) @(negedge clk);
    fail_count += awaited_outputs.size();
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("TB_ERROR");
    $finish;
  end

endmodule
